### rtl/ildh_pkg.sv
// ----------------------------------------------------------------------------
// ildh_pkg
// Shared types and constants of the interrupt line debounce and hold block.
// ----------------------------------------------------------------------------
package ildh_pkg;

  // Parameter defaults
  localparam int LINE_COUNT_DEF  = 16;
  localparam int TICK_DIVIDE_DEF = 4;

  // Fixed field widths
  localparam int MASK_W  = 16;
  localparam int LIDX_W  = 4;
  localparam int MS_W    = 16;
  localparam int TICKS_W = 4;
  localparam int CNT_W   = 15;
  localparam int PHASE_W = 2;
  localparam int FLAGS_W = 3;
  localparam int CFG_A_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Operation carried with each item
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_EDGE   = 2'd1,
    OP_ARM    = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_FALL_MASK  = 3'd0,
    REG_RISE_MASK  = 3'd1,
    REG_LEVEL_MASK = 3'd2,
    REG_DEB_LINES  = 3'd3,
    REG_DEB_TICKS  = 3'd4
  } reg_idx_t;

  // Line debounce phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SETTLE    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_IDLE = 2'd2;

  // Hold flag bit positions and values
  localparam int FLAG_ARMED_B   = 0;
  localparam int FLAG_PRESSED_B = 1;
  localparam int FLAG_DEB_B     = 2;
  localparam logic [FLAGS_W-1:0] FLAGS_NONE  = 3'b000;
  localparam logic [FLAGS_W-1:0] FLAGS_ARMED = 3'b001;

  // Configuration reset values
  localparam logic [MASK_W-1:0]  FALL_RST  = 16'h0001;
  localparam logic [MASK_W-1:0]  RISE_RST  = 16'h8800;
  localparam logic [MASK_W-1:0]  LEVEL_RST = 16'h8800;
  localparam logic [MASK_W-1:0]  DEB_RST   = 16'h8801;
  localparam logic [TICKS_W-1:0] TICKS_RST = 4'd3;

endpackage

### rtl/interrupt_line_debounce_hold.sv
// Throughput: one item per cycle unless out_tready stalls the result stage;
// all lines update in parallel in one pass.
// The input register and the result register form a two-stage pipeline.
// Reset (rst_n low, synchronous) idles every line, enables all interrupts,
// clears the hold detector and loads the configuration defaults.
// ----------------------------------------------------------------------------
// interrupt_line_debounce_hold
// Per-line edge masking and tick-driven debouncing, with a long-press
// detector on line 0.
// ----------------------------------------------------------------------------
module interrupt_line_debounce_hold
  import ildh_pkg::*;
#(
  parameter int LINE_COUNT  = LINE_COUNT_DEF,
  parameter int TICK_DIVIDE = TICK_DIVIDE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write port
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [MASK_W-1:0]  cfg_wdata,
  // Input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,   // line_index[3:0], pin_levels[19:4], hold_ms[35:20]
  input  logic [1:0]         in_tuser,   // operation[1:0]
  // Result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata   // interrupt_enable[15:0], hold_passed[16],
                                         // hold_indicator[17], hold_status[20:18]
);

  // Lines past the mask width can never be debounced, so they hold no state.
  localparam int ACT_LINES = (LINE_COUNT < MASK_W) ? LINE_COUNT : MASK_W;
  localparam int TP_W      = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
  localparam logic [TP_W-1:0] TP_LAST = TP_W'(TICK_DIVIDE - 1);

  // hold_ms / TICK_DIVIDE by reciprocal multiply; exact over the 16-bit range.
  localparam int RECIP_SHIFT = MS_W + $clog2(TICK_DIVIDE);
  localparam int RECIP_W     = MS_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TICK_DIVIDE) - 64'd1) / 64'(TICK_DIVIDE));

  // Configuration registers
  logic [MASK_W-1:0]  fall_r, rise_r, level_r, deb_r;
  logic [TICKS_W-1:0] ticks_r;

  // Input stage
  logic              s1_v_r;
  op_t               s1_op_r;
  logic [LIDX_W-1:0] s1_line_r;
  logic [MASK_W-1:0] s1_pins_r;
  logic [MS_W-1:0]   s1_ms_r;

  // Block state
  logic [PHASE_W-1:0] phase_r [ACT_LINES];
  logic [PHASE_W-1:0] phase_nxt [ACT_LINES];
  logic [TICKS_W-1:0] wait_r [ACT_LINES];
  logic [TICKS_W-1:0] wait_nxt [ACT_LINES];
  logic [MASK_W-1:0]  en_r, en_nxt;
  logic [TP_W-1:0]    tick_r, tick_nxt;
  logic [FLAGS_W-1:0] flags_r, flags_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic               lamp_r, lamp_nxt;
  logic               out_v_r;

  logic                       out_adv, step, tick_fire;
  logic [ACT_LINES-1:0]       edge_hit;
  logic [CNT_W-1:0]           cnt_dec;
  logic [MS_W+RECIP_W-1:0]    ms_prod;
  logic [MS_W:0]              arm_sum;
  logic [CNT_W-1:0]           arm_cnt;

  assign out_adv   = !out_v_r || out_tready;
  assign step      = s1_v_r && out_adv;
  assign in_tready = !s1_v_r || out_adv;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, flags_r, lamp_r, done_r, en_r};

  assign ms_prod = s1_ms_r * RECIP;
  assign arm_sum = (MS_W+1)'(ms_prod >> RECIP_SHIFT) + 1'b1;
  assign arm_cnt = (arm_sum > (MS_W+1)'(CNT_MAX)) ? CNT_MAX : arm_sum[CNT_W-1:0];

  assign cnt_dec = cnt_r - 1'b1;

  always_comb begin
    tick_nxt  = tick_r;
    tick_fire = 1'b0;
    if (step && s1_op_r == OP_TICK) begin
      tick_nxt  = (tick_r == TP_LAST) ? '0 : tick_r + 1'b1;
      tick_fire = (tick_r == TP_LAST);
    end
  end

  always_comb begin
    en_nxt = en_r;
    for (int i = 0; i < ACT_LINES; i++) begin
      phase_nxt[i] = phase_r[i];
      wait_nxt[i]  = wait_r[i];
      edge_hit[i]  = step && s1_op_r == OP_EDGE && s1_line_r == LIDX_W'(i) &&
                     deb_r[i] && en_r[i];
      if (tick_fire && deb_r[i] && phase_r[i] != PH_IDLE) begin
        if (wait_r[i] != '0) begin
          wait_nxt[i] = wait_r[i] - 1'b1;
        end else if (phase_r[i] == PH_WAIT_IDLE) begin
          // The pin must be back at the idle level of its active edge.
          if ((s1_pins_r[i] && fall_r[i]) || (!s1_pins_r[i] && rise_r[i])) begin
            phase_nxt[i] = PH_SETTLE;
            wait_nxt[i]  = ticks_r;
          end
        end else if (phase_r[i] == PH_SETTLE) begin
          phase_nxt[i] = PH_IDLE;
          en_nxt[i]    = 1'b1;
        end
      end
      if (edge_hit[i]) begin
        en_nxt[i]    = 1'b0;
        wait_nxt[i]  = ticks_r;
        phase_nxt[i] = level_r[i] ? PH_WAIT_IDLE : PH_SETTLE;
      end
    end
  end

  // Long-press detector; it sees line 0 after this tick's debounce step.
  always_comb begin
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    lamp_nxt  = lamp_r;
    if (step) begin
      case (s1_op_r)
        OP_TICK: begin
          if (tick_fire && flags_r[FLAG_PRESSED_B]) begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == '0) begin
              done_nxt  = 1'b1;
              flags_nxt = FLAGS_NONE;
              lamp_nxt  = 1'b0;
            end
            if (flags_nxt[FLAG_DEB_B] && phase_nxt[0] == PH_IDLE) begin
              flags_nxt[FLAG_DEB_B] = 1'b0;
              if (!s1_pins_r[0]) begin
                flags_nxt = FLAGS_ARMED;
                lamp_nxt  = 1'b0;
              end
            end
          end
        end
        OP_EDGE: begin
          if (edge_hit[0] && flags_r[FLAG_ARMED_B]) begin
            if (s1_pins_r[0]) begin
              flags_nxt[FLAG_DEB_B]     = 1'b1;
              flags_nxt[FLAG_PRESSED_B] = 1'b1;
              lamp_nxt                  = 1'b1;
            end else begin
              flags_nxt = FLAGS_ARMED;
              lamp_nxt  = 1'b0;
            end
          end
        end
        OP_ARM: begin
          cnt_nxt   = arm_cnt;
          flags_nxt = FLAGS_ARMED;
          done_nxt  = 1'b0;
        end
        OP_CANCEL: begin
          flags_nxt = FLAGS_NONE;
        end
        default: begin
          flags_nxt = flags_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_r  <= FALL_RST;
      rise_r  <= RISE_RST;
      level_r <= LEVEL_RST;
      deb_r   <= DEB_RST;
      ticks_r <= TICKS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_FALL_MASK:  fall_r  <= cfg_wdata;
        REG_RISE_MASK:  rise_r  <= cfg_wdata;
        REG_LEVEL_MASK: level_r <= cfg_wdata;
        REG_DEB_LINES:  deb_r   <= cfg_wdata;
        REG_DEB_TICKS:  ticks_r <= cfg_wdata[TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= op_t'(in_tuser);
      s1_line_r <= in_tdata[LIDX_W-1:0];
      s1_pins_r <= in_tdata[LIDX_W +: MASK_W];
      s1_ms_r   <= in_tdata[LIDX_W+MASK_W +: MS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      en_r    <= '1;
      tick_r  <= '0;
      flags_r <= FLAGS_NONE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      lamp_r  <= 1'b0;
      for (int i = 0; i < ACT_LINES; i++) begin
        phase_r[i] <= PH_IDLE;
        wait_r[i]  <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
      en_r    <= en_nxt;
      tick_r  <= tick_nxt;
      flags_r <= flags_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      lamp_r  <= lamp_nxt;
      for (int i = 0; i < ACT_LINES; i++) begin
        phase_r[i] <= phase_nxt[i];
        wait_r[i]  <= wait_nxt[i];
      end
    end
  end

endmodule

### bench/interrupt_line_debounce_hold_test.sv
// ----------------------------------------------------------------------------
// interrupt_line_debounce_hold_test
// Self-checking bench for the interrupt line debouncer with its long-press
// detector. A tracker class keeps its own copy of the line phases, wait
// counts, enable mask and hold state, and predicts the result word of every
// accepted item. Stimulus is a directed opening followed by random press
// sequences and noise under several register settings, with random idling
// on both streams and one long hold-off on the result side.
// ----------------------------------------------------------------------------
import ildh_pkg::*;

typedef struct packed {
  logic [MASK_W-1:0]  irq_enable;
  logic               passed;
  logic               lamp;
  logic [FLAGS_W-1:0] status;
} status_word_t;

class line_hold_tracker;
  logic [MASK_W-1:0]  fall_mask;
  logic [MASK_W-1:0]  rise_mask;
  logic [MASK_W-1:0]  level_mask;
  logic [MASK_W-1:0]  deb_lines;
  logic [TICKS_W-1:0] deb_ticks;

  logic [PHASE_W-1:0] line_ph [LINE_COUNT_DEF];
  logic [TICKS_W-1:0] settle_cnt [LINE_COUNT_DEF];
  logic [MASK_W-1:0]  irq_enable;
  int                 tick_div;
  logic [FLAGS_W-1:0] flags;
  logic [CNT_W-1:0]   press_left;
  logic               passed;
  logic               lamp;

  status_word_t awaited_words[$];
  int mismatches;
  int checked;
  int unmasks;
  int holds_done;
  int releases;

  function new();
    fall_mask  = FALL_RST;
    rise_mask  = RISE_RST;
    level_mask = LEVEL_RST;
    deb_lines  = DEB_RST;
    deb_ticks  = TICKS_RST;
    for (int i = 0; i < LINE_COUNT_DEF; i++) begin
      line_ph[i]    = PH_IDLE;
      settle_cnt[i] = '0;
    end
    irq_enable = '1;
    tick_div   = 0;
    flags      = FLAGS_NONE;
    press_left = '0;
    passed     = 1'b0;
    lamp       = 1'b0;
    mismatches = 0;
    checked    = 0;
    unmasks    = 0;
    holds_done = 0;
    releases   = 0;
  endfunction

  function void write_reg(reg_idx_t idx, logic [MASK_W-1:0] value);
    case (idx)
      REG_FALL_MASK:  fall_mask  = value;
      REG_RISE_MASK:  rise_mask  = value;
      REG_LEVEL_MASK: level_mask = value;
      REG_DEB_LINES:  deb_lines  = value;
      REG_DEB_TICKS:  deb_ticks  = value[TICKS_W-1:0];
      default: ;
    endcase
  endfunction

  function void settle_line(int n, logic [MASK_W-1:0] pins);
    if (settle_cnt[n] != 0) begin
      settle_cnt[n] = settle_cnt[n] - 1'b1;
    end else if (line_ph[n] == PH_WAIT_IDLE) begin
      // Leave the wait once the pin sits at the idle level of its active edge.
      if ((pins[n] && fall_mask[n]) || (!pins[n] && rise_mask[n])) begin
        line_ph[n]    = PH_SETTLE;
        settle_cnt[n] = deb_ticks;
      end
    end else if (line_ph[n] == PH_SETTLE) begin
      line_ph[n]    = PH_IDLE;
      irq_enable[n] = 1'b1;
      unmasks++;
    end
  endfunction

  function void press_check(logic [MASK_W-1:0] pins);
    if (!flags[FLAG_PRESSED_B]) return;
    press_left = press_left - 1'b1;
    if (press_left == 0) begin
      passed = 1'b1;
      flags  = FLAGS_NONE;
      lamp   = 1'b0;
      holds_done++;
    end
    // The press is judged only once line 0 has finished its debounce.
    if (flags[FLAG_DEB_B] && line_ph[0] == PH_IDLE) begin
      flags[FLAG_DEB_B] = 1'b0;
      if (!pins[0]) begin
        flags = FLAGS_ARMED;
        lamp  = 1'b0;
        releases++;
      end
    end
  endfunction

  function void tick(logic [MASK_W-1:0] pins);
    tick_div = (tick_div + 1) % TICK_DIVIDE_DEF;
    if (tick_div != 0) return;
    for (int i = 0; i < LINE_COUNT_DEF; i++) begin
      if (deb_lines[i] && line_ph[i] != PH_IDLE) settle_line(i, pins);
      if (i == 0) press_check(pins);
    end
  endfunction

  function void edge_seen(int n, logic [MASK_W-1:0] pins);
    if (!deb_lines[n] || !irq_enable[n]) return;
    irq_enable[n] = 1'b0;
    settle_cnt[n] = deb_ticks;
    line_ph[n]    = level_mask[n] ? PH_WAIT_IDLE : PH_SETTLE;
    if (n == 0 && flags[FLAG_ARMED_B]) begin
      if (pins[0]) begin
        flags[FLAG_PRESSED_B] = 1'b1;
        flags[FLAG_DEB_B]     = 1'b1;
        lamp = 1'b1;
      end else begin
        flags = FLAGS_ARMED;
        lamp  = 1'b0;
      end
    end
  endfunction

  function void take_item(op_t op, logic [LIDX_W-1:0] line, logic [MASK_W-1:0] pins,
                          logic [MS_W-1:0] ms);
    int unsigned  cnt;
    status_word_t w;
    case (op)
      OP_TICK: tick(pins);
      OP_EDGE: edge_seen(int'(line), pins);
      OP_ARM: begin
        cnt        = 1 + ms / TICK_DIVIDE_DEF;
        press_left = (cnt > CNT_MAX) ? CNT_MAX : cnt[CNT_W-1:0];
        flags      = FLAGS_ARMED;
        passed     = 1'b0;
      end
      default: flags = FLAGS_NONE;
    endcase
    w.irq_enable = irq_enable;
    w.passed     = passed;
    w.lamp       = lamp;
    w.status     = flags;
    awaited_words.push_back(w);
  endfunction

  function void check_result(logic [23:0] data);
    status_word_t got;
    status_word_t want;
    got.irq_enable = data[15:0];
    got.passed     = data[16];
    got.lamp       = data[17];
    got.status     = data[20:18];
    if (awaited_words.size() == 0) begin
      if (mismatches < 10)
        $display("ERROR: result item with nothing pending:",
                 " enable=%h passed=%b lamp=%b status=%b",
                 got.irq_enable, got.passed, got.lamp, got.status);
      mismatches++;
      return;
    end
    want = awaited_words.pop_front();
    checked++;
    if (got !== want) begin
      if (mismatches < 10)
        $display("ERROR: result %0d: expected enable=%h passed=%b lamp=%b status=%b,",
                 checked, want.irq_enable, want.passed, want.lamp, want.status,
                 " got enable=%h passed=%b lamp=%b status=%b",
                 got.irq_enable, got.passed, got.lamp, got.status);
      mismatches++;
    end
  endfunction
endclass

module interrupt_line_debounce_hold_test;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 200;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr   = '0;
  logic [MASK_W-1:0]  cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [39:0]        in_tdata   = '0;  // line_index[3:0], pin_levels[19:4], hold_ms[35:20]
  logic [1:0]         in_tuser   = '0;  // operation[1:0]
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [23:0]        out_tdata;        // interrupt_enable[15:0], hold_passed[16],
                                        // hold_indicator[17], hold_status[20:18]

  line_hold_tracker tracker = new();

  bit gaps_on      = 1'b0;
  bit sink_stalls  = 1'b0;
  bit hold_off_req = 1'b0;
  int items_sent   = 0;
  int settings_run = 0;
  int stuck_cycles = 0;

  interrupt_line_debounce_hold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Inputs are noted before results so that the order never matters.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tracker.take_item(op_t'(in_tuser), in_tdata[3:0], in_tdata[19:4], in_tdata[35:20]);
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input op_t op, input logic [LIDX_W-1:0] line,
                           input logic [MASK_W-1:0] pins, input logic [MS_W-1:0] ms);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, ms, pins, line};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [MASK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  task automatic set_config(input logic [MASK_W-1:0] fall, rise, level, lines,
                            input logic [TICKS_W-1:0] ticks);
    write_reg(REG_FALL_MASK, fall);
    write_reg(REG_RISE_MASK, rise);
    write_reg(REG_LEVEL_MASK, level);
    write_reg(REG_DEB_LINES, lines);
    write_reg(REG_DEB_TICKS, {{(MASK_W-TICKS_W){1'b0}}, ticks});
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Waits out every pending result and then the pipeline depth. The first
  // edge lets the monitor note an item accepted at the edge just passed.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [MS_W-1:0] pick_ms();
    if ($urandom_range(0, 9) == 0) return MS_W'($urandom);
    return MS_W'($urandom_range(0, 60));
  endfunction

  // Arm, press line 0 and hold it for a while, then let go.
  task automatic press_sequence();
    logic [MASK_W-1:0] pins;
    int held;
    int len;
    held = $urandom_range(2, 40);
    len  = held + $urandom_range(4, 30);
    send_item(OP_ARM, LIDX_W'($urandom), MASK_W'($urandom), pick_ms());
    pins = MASK_W'($urandom);
    pins[0] = 1'b1;
    send_item(OP_EDGE, '0, pins, MS_W'($urandom));
    for (int k = 0; k < len; k++) begin
      pins = MASK_W'($urandom);
      pins[0] = (k < held);
      if ($urandom_range(0, 7) == 0)
        send_item(OP_EDGE, LIDX_W'($urandom), pins, MS_W'($urandom));
      else
        send_item(OP_TICK, LIDX_W'($urandom), pins, MS_W'($urandom));
    end
  endtask

  task automatic run_random(input int count, input bit allow_idle);
    int target;
    int r;
    op_t op;
    logic [LIDX_W-1:0] line;
    target = items_sent + count;
    while (items_sent < target) begin
      if (allow_idle && $urandom_range(0, 15) == 0) begin
        gaps_on     = ($urandom_range(0, 2) != 0);
        sink_stalls = ($urandom_range(0, 2) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        press_sequence();
      end else begin
        if (r < 55)      op = OP_TICK;
        else if (r < 85) op = OP_EDGE;
        else if (r < 94) op = OP_ARM;
        else             op = OP_CANCEL;
        line = ($urandom_range(0, 3) == 0) ? '0 : LIDX_W'($urandom);
        send_item(op, line, MASK_W'($urandom), pick_ms());
      end
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on     = 1'b1;
    sink_stalls = 1'b1;

    // Opening under the reset settings: extremes, an ignored edge, a
    // level-checked line and a maximal arm.
    send_item(OP_CANCEL, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(OP_EDGE,   4'd3,  16'h0000, 16'h0000);
    send_item(OP_EDGE,   4'd11, 16'hFFFF, 16'h0000);
    send_item(OP_ARM,    4'd0,  16'h0000, 16'hFFFF);
    send_item(OP_TICK,   4'd0,  16'h0000, 16'h0000);
    drain();

    // With no debounce wait, a press on line 0 finishes within one divided
    // tick, then a second press is released early and an unpressed edge
    // while armed only masks the line.
    set_config(16'h00FF, 16'hFF01, 16'hFF00, 16'hFFFF, 4'd0);
    send_item(OP_ARM,    4'd0,  16'h0000, 16'h0000);
    send_item(OP_EDGE,   4'd0,  16'h0001, 16'h0000);
    send_item(OP_EDGE,   4'd0,  16'h0001, 16'h0000);
    send_item(OP_EDGE,   4'd15, 16'h0000, 16'h0000);
    repeat (4) send_item(OP_TICK, 4'd0, 16'h0001, 16'h0000);
    send_item(OP_ARM,    4'd0,  16'h0000, 16'h0008);
    send_item(OP_EDGE,   4'd0,  16'h0001, 16'h0000);
    repeat (4) send_item(OP_TICK, 4'd0, 16'h0000, 16'h0000);
    send_item(OP_EDGE,   4'd0,  16'h0000, 16'h0000);
    send_item(OP_EDGE,   4'd7,  16'hFFFF, 16'h0000);
    repeat (2) send_item(OP_TICK, 4'd0, 16'hFFFF, 16'h0000);
    drain();

    set_config(FALL_RST, RISE_RST, LEVEL_RST, DEB_RST, TICKS_RST);
    run_random(300, 1'b1);
    drain();

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
    run_random(150, 1'b1);
    // Hold the result side off while items keep coming, so the block backs up.
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    run_random(40, 1'b0);
    run_random(150, 1'b1);
    drain();

    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0);
    run_random(100, 1'b1);
    drain();

    begin : complementary_edges
      logic [MASK_W-1:0] fall;
      fall = MASK_W'($urandom);
      set_config(fall, ~fall, MASK_W'($urandom), 16'hFFFF, 4'd1);
    end
    run_random(300, 1'b1);
    drain();

    set_config(MASK_W'($urandom), MASK_W'($urandom), MASK_W'($urandom),
               MASK_W'($urandom) | 16'h0001, TICKS_W'($urandom));
    run_random(300, 1'b1);
    drain();

    // Last part: both sides run without idling.
    gaps_on     = 1'b0;
    sink_stalls = 1'b0;
    set_config(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 4'd0);
    run_random(440, 1'b0);
    drain();

    $display("Covered %0d items over %0d register settings,", items_sent, settings_run,
             " with idle bursts on both sides");
    $display("and one long result hold-off; %0d line re-enables,", tracker.unmasks,
             " %0d completed and %0d released presses.",
             tracker.holds_done, tracker.releases);
    if (tracker.mismatches == 0 && tracker.awaited_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d result items failed out of %0d checked.",
               tracker.mismatches, tracker.checked);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ildh_pkg.sv
rtl/interrupt_line_debounce_hold.sv
bench/interrupt_line_debounce_hold_test.sv
